/* rtl/button_auto_repeat_edges_defines.svh */
// ----------------------------------------------------------------------------
// button_auto_repeat_edges_defines
// Assertion macros shared by the button auto-repeat RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTO_REPEAT_EDGES_DEFINES_SVH
`define BUTTON_AUTO_REPEAT_EDGES_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BARE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BARE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bare_pkg.sv */
// ----------------------------------------------------------------------------
// bare_pkg
// Types and constants for the button auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package bare_pkg;

  localparam int unsigned MASK_W      = 16;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned BUTTONS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 8'd1;

  localparam logic [CNT_W-1:0] DELAY_RST    = 8'd12;
  localparam logic [CNT_W-1:0] INTERVAL_RST = 8'd4;

  // Per-button operands of the shared update unit
  typedef struct packed {
    logic             held;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] phase;
    logic [CNT_W-1:0] delay;     // already forced to at least one
    logic [CNT_W-1:0] interval;  // already forced to at least one
  } step_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] phase;
    logic             rep;
    logic             press;
  } step_out_t;

endpackage

`default_nettype wire

/* rtl/bare_step.sv */
// ----------------------------------------------------------------------------
// bare_step
// Hold-count / repeat-phase update for one button.
// ----------------------------------------------------------------------------
`default_nettype none

module bare_step (
  input  bare_pkg::step_in_t  step_in,
  output bare_pkg::step_out_t step_out
);

  logic [bare_pkg::CNT_W-1:0] cnt_inc;
  logic [bare_pkg::CNT_W:0]   phase_inc;

  always_comb begin
    cnt_inc   = step_in.count + 8'd1;
    phase_inc = {1'b0, step_in.phase} + 9'd1;
    step_out  = '0;
    if (!step_in.held) begin
      step_out = '0;
    end else if (step_in.count < step_in.delay) begin
      // still counting toward the delay point
      step_out.count = cnt_inc;
      step_out.phase = (cnt_inc == step_in.delay) ? '0 : step_in.phase;
      step_out.press = (cnt_inc == 8'd1);
      step_out.rep   = (cnt_inc == 8'd1) || (cnt_inc == step_in.delay);
    end else begin
      step_out.count = step_in.count;
      if (phase_inc >= {1'b0, step_in.interval}) begin
        step_out.rep   = 1'b1;
        step_out.phase = '0;
      end else begin
        step_out.phase = phase_inc[bare_pkg::CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/button_auto_repeat_edges.sv */
// ----------------------------------------------------------------------------
// button_auto_repeat_edges
// Per-frame button sampler: held, press, release and auto-repeat masks.
// ----------------------------------------------------------------------------
// One sample is taken per transfer on the input channel. Buttons are walked
// one per clock through a single shared update unit. After the last button the
// result waits in a done state until the output register is free, and is then
// loaded into it; in_ready is low from acceptance until that load. The
// output register holds the result until taken, and the next sample may be
// accepted while it waits. Configuration writes are taken every cycle.
`default_nettype none

`include "button_auto_repeat_edges_defines.svh"

module button_auto_repeat_edges #(
  parameter int unsigned BUTTONS = bare_pkg::BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bare_pkg::MASK_W-1:0]    in_held_now,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bare_pkg::MASK_W-1:0]         out_held_mask,
  output logic [bare_pkg::MASK_W-1:0]         out_repeat_mask,
  output logic [bare_pkg::MASK_W-1:0]         out_press_mask,
  output logic [bare_pkg::MASK_W-1:0]         out_release_mask,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bare_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bare_pkg::CNT_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [bare_pkg::CNT_W-1:0]   delay_r, interval_r;
  logic [bare_pkg::CNT_W-1:0]   hold_cnt_r [BUTTONS];
  logic [bare_pkg::CNT_W-1:0]   phase_r    [BUTTONS];
  logic [bare_pkg::MASK_W-1:0]  prev_r, sample_r, release_r;
  logic [bare_pkg::MASK_W-1:0]  rep_acc_r, rep_acc_nxt;
  logic [bare_pkg::MASK_W-1:0]  press_acc_r, press_acc_nxt;
  logic                         out_valid_r;
  logic [bare_pkg::MASK_W-1:0]  out_held_r, out_rep_r, out_press_r, out_rel_r;

  logic                         in_xfer, cfg_xfer, out_load;
  logic [4:0]                   idx5;
  logic                         bit_live;
  bare_pkg::step_in_t           step_in;
  bare_pkg::step_out_t          step_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Buttons above the sample width are never held
  assign idx5     = 5'(idx_r);
  assign bit_live = ~idx5[4];

  always_comb begin
    step_in.held     = bit_live && sample_r[idx5[3:0]];
    step_in.count    = hold_cnt_r[idx_r];
    step_in.phase    = phase_r[idx_r];
    step_in.delay    = (delay_r == '0) ? 8'd1 : delay_r;
    step_in.interval = (interval_r == '0) ? 8'd1 : interval_r;
  end

  bare_step u_step (
    .step_in  (step_in),
    .step_out (step_out)
  );

  always_comb begin
    rep_acc_nxt   = rep_acc_r |
                    (bare_pkg::MASK_W'(step_out.rep & bit_live) << idx5[3:0]);
    press_acc_nxt = press_acc_r |
                    (bare_pkg::MASK_W'(step_out.press & bit_live) << idx5[3:0]);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RUN;
          idx_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      delay_r     <= bare_pkg::DELAY_RST;
      interval_r  <= bare_pkg::INTERVAL_RST;
      prev_r      <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        hold_cnt_r[i] <= '0;
        phase_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_xfer) begin
        if (cfg_index == bare_pkg::REG_DELAY) begin
          delay_r <= cfg_data;
        end else if (cfg_index == bare_pkg::REG_INTERVAL) begin
          interval_r <= cfg_data;
        end
      end
      if (in_xfer) begin
        prev_r <= in_held_now;
      end
      if (state_r == ST_RUN) begin
        hold_cnt_r[idx_r] <= step_out.count;
        phase_r[idx_r]    <= step_out.phase;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r    <= in_held_now;
      release_r   <= prev_r & ~in_held_now;
      rep_acc_r   <= '0;
      press_acc_r <= '0;
    end else if (state_r == ST_RUN) begin
      rep_acc_r   <= rep_acc_nxt;
      press_acc_r <= press_acc_nxt;
    end
    if (out_load) begin
      out_held_r  <= sample_r;
      out_rep_r   <= rep_acc_r;
      out_press_r <= press_acc_r;
      out_rel_r   <= release_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_held_mask    = out_held_r;
  assign out_repeat_mask  = out_rep_r;
  assign out_press_mask   = out_press_r;
  assign out_release_mask = out_rel_r;

  `BARE_ASSERT_NEXT(a_start_walk, in_xfer, (state_r == ST_RUN) && (idx_r == '0), "walk did not start at button zero")
  `BARE_ASSERT_NEXT(a_walk_step, (state_r == ST_RUN) && (idx_r != IDX_LAST), (state_r == ST_RUN) && (idx_r == $past(idx_r) + 1'b1), "button index skipped")
  `BARE_ASSERT_NEXT(a_walk_end, (state_r == ST_RUN) && (idx_r == IDX_LAST), state_r == ST_DONE, "walk did not finish after last button")
  `BARE_ASSERT_NEXT(a_result_load, out_load, out_valid_r && (state_r == ST_IDLE), "result not presented after walk")

endmodule

`default_nettype wire

/* verif/tb_button_auto_repeat_edges.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_auto_repeat_edges
// Self-checking bench for the button auto-repeat and edge detector.
// A per-button hold/phase model runs beside the block and predicts the held,
// repeat, press and release masks of every sample; each result transfer is
// compared field by field. Directed holds cover the first tick after reset,
// zero and full-scale timing registers and timing changes in mid-hold. Then
// come long random hold patterns under several timing settings and three
// handshake throttling mixes.
// ----------------------------------------------------------------------------

module tb_button_auto_repeat_edges;

  localparam int STALL_LIMIT = 2000;
  localparam logic [bare_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  typedef struct packed {
    logic [bare_pkg::MASK_W-1:0] held;
    logic [bare_pkg::MASK_W-1:0] rpt;
    logic [bare_pkg::MASK_W-1:0] press;
    logic [bare_pkg::MASK_W-1:0] rel;
  } masks_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [bare_pkg::MASK_W-1:0]    in_held_now = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bare_pkg::MASK_W-1:0]    out_held_mask;
  logic [bare_pkg::MASK_W-1:0]    out_repeat_mask;
  logic [bare_pkg::MASK_W-1:0]    out_press_mask;
  logic [bare_pkg::MASK_W-1:0]    out_release_mask;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bare_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bare_pkg::CNT_W-1:0]     cfg_data = '0;

  // model state
  logic [bare_pkg::CNT_W-1:0]  delay_reg;
  logic [bare_pkg::CNT_W-1:0]  interval_reg;
  logic [bare_pkg::CNT_W-1:0]  hold_cnt [bare_pkg::BUTTONS_DEF];
  logic [bare_pkg::CNT_W-1:0]  rep_phase [bare_pkg::BUTTONS_DEF];
  logic [bare_pkg::MASK_W-1:0] last_sample;

  masks_t pending_results [$];
  int     errors = 0;
  int     quiet_cycles = 0;
  int     in_idle_pct = 36;
  int     out_idle_pct = 73;

  button_auto_repeat_edges u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_held_now      (in_held_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_held_mask    (out_held_mask),
    .out_repeat_mask  (out_repeat_mask),
    .out_press_mask   (out_press_mask),
    .out_release_mask (out_release_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic masks_t predict_sample(input logic [bare_pkg::MASK_W-1:0] held);
    masks_t                     res;
    logic [bare_pkg::CNT_W-1:0] eff_delay;
    logic [bare_pkg::CNT_W-1:0] eff_intv;
    logic [bare_pkg::CNT_W:0]   nxt;
    res = '0;
    eff_delay = (delay_reg == '0) ? bare_pkg::CNT_W'(1) : delay_reg;
    eff_intv  = (interval_reg == '0) ? bare_pkg::CNT_W'(1) : interval_reg;
    for (int i = 0; i < bare_pkg::BUTTONS_DEF; i++) begin
      if (!held[i]) begin
        hold_cnt[i]  = '0;
        rep_phase[i] = '0;
      end else if (hold_cnt[i] < eff_delay) begin
        hold_cnt[i] = hold_cnt[i] + 1'b1;
        if (hold_cnt[i] == bare_pkg::CNT_W'(1)) begin
          res.rpt[i]   = 1'b1;
          res.press[i] = 1'b1;
        end
        if (hold_cnt[i] == eff_delay) begin
          res.rpt[i]   = 1'b1;
          rep_phase[i] = '0;
        end
      end else begin
        nxt = {1'b0, rep_phase[i]} + 1'b1;
        if (nxt >= {1'b0, eff_intv}) begin
          res.rpt[i] = 1'b1;
          nxt = '0;
        end
        rep_phase[i] = nxt[bare_pkg::CNT_W-1:0];
      end
    end
    res.held    = held;
    res.rel     = last_sample & ~held;
    last_sample = held;
    return res;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [bare_pkg::MASK_W-1:0] exp_v,
                                      input logic [bare_pkg::MASK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // transfer monitor: prediction, checking and register tracking
  always @(posedge clk) begin : monitor
    masks_t exp_r;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual held %h rpt %h press %h rel %h",
                   $time, out_held_mask, out_repeat_mask, out_press_mask, out_release_mask);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("held_mask", exp_r.held, out_held_mask);
          check_field("repeat_mask", exp_r.rpt, out_repeat_mask);
          check_field("press_mask", exp_r.press, out_press_mask);
          check_field("release_mask", exp_r.rel, out_release_mask);
        end
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          bare_pkg::REG_DELAY:    delay_reg = cfg_data;
          bare_pkg::REG_INTERVAL: interval_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        pending_results.push_back(predict_sample(in_held_now));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("button_auto_repeat_edges: mismatch");
    $finish;
  end

  task automatic send_sample(input logic [bare_pkg::MASK_W-1:0] held);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_held_now <= held;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and let every sample in flight come back
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // delay, interval, then an unmapped index that must be ignored
  task automatic set_timing(input logic [bare_pkg::CNT_W-1:0] delay_v,
                            input logic [bare_pkg::CNT_W-1:0] intv_v);
    cfg_valid <= 1'b1;
    cfg_index <= bare_pkg::REG_DELAY;
    cfg_data  <= delay_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= bare_pkg::REG_INTERVAL;
    cfg_data  <= intv_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_UNMAPPED;
    cfg_data  <= bare_pkg::CNT_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [bare_pkg::CNT_W-1:0] pick_timing(
    input logic [bare_pkg::CNT_W-1:0] rst_v
  );
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return rst_v;
      default: return bare_pkg::CNT_W'($urandom_range(6, 1));
    endcase
  endfunction

  // previous sample resets to all ones: unheld buttons show as released
  task automatic test_first_tick();
    send_sample(16'h00F0);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
  endtask

  task automatic test_zero_registers();
    wait_idle(8);
    set_timing('0, '0);
    repeat (3) send_sample(16'h8001);
    send_sample(16'h0000);
  endtask

  task automatic test_register_extremes();
    wait_idle(8);
    set_timing('1, '1);
    repeat (2) send_sample(16'hFFFF);
    send_sample(16'h0000);
  endtask

  task automatic test_timing_change_mid_hold();
    wait_idle(8);
    set_timing(8'd3, 8'd5);
    repeat (4) send_sample(16'h8001);
    // count already past the new delay: phase fires at once
    wait_idle(8);
    set_timing(8'd2, 8'd1);
    repeat (2) send_sample(16'h8001);
    // count below the new delay: counting resumes
    wait_idle(8);
    set_timing(8'd6, 8'd2);
    repeat (3) send_sample(16'h8001);
    send_sample(16'h0000);
  endtask

  // long-lived hold patterns with sparse bit flips, plus some noise
  task automatic test_random_holds(input int n_items);
    logic [bare_pkg::MASK_W-1:0] mask;
    mask = '0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        wait_idle(8);
        set_timing(pick_timing(bare_pkg::DELAY_RST), pick_timing(bare_pkg::INTERVAL_RST));
      end
      case ($urandom_range(19))
        0, 1:    mask = bare_pkg::MASK_W'($urandom);
        2:       mask = '0;
        default: begin
          if ($urandom_range(1) == 1) mask ^= bare_pkg::MASK_W'($urandom & $urandom & $urandom);
        end
      endcase
      send_sample(mask);
    end
  endtask

  initial begin
    delay_reg    = bare_pkg::DELAY_RST;
    interval_reg = bare_pkg::INTERVAL_RST;
    last_sample  = '1;
    for (int i = 0; i < bare_pkg::BUTTONS_DEF; i++) begin
      hold_cnt[i]  = '0;
      rep_phase[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_first_tick();
    test_zero_registers();
    test_register_extremes();
    test_timing_change_mid_hold();
    test_random_holds(260);
    in_idle_pct  = 73;
    out_idle_pct = 36;
    test_random_holds(260);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_holds(260);

    wait_idle(40);
    if (errors == 0) begin
      $display("button_auto_repeat_edges: match");
    end else begin
      $display("button_auto_repeat_edges: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bare_pkg.sv
rtl/bare_step.sv
rtl/button_auto_repeat_edges.sv
verif/tb_button_auto_repeat_edges.sv
